// ----- rtl/icm_pkg.sv -----
`timescale 1ns / 1ps

package icm_pkg;

  // Curve select codes for the mode register
  localparam logic [1:0] MODE_BD    = 2'd0;
  localparam logic [1:0] MODE_SPLIT = 2'd1;
  localparam logic [1:0] MODE_WV    = 2'd2;

  // Pipeline depth from input capture to output register
  localparam int unsigned PIPE_DEPTH = 6;

  // Thresholds in centikelvin
  localparam logic [15:0] K_30315 = 16'd30315;
  localparam logic [15:0] K_28215 = 16'd28215;
  localparam logic [15:0] K_27315 = 16'd27315;
  localparam logic [15:0] K_26315 = 16'd26315;
  localparam logic [15:0] K_25315 = 16'd25315;
  localparam logic [15:0] K_24315 = 16'd24315;
  localparam logic [15:0] K_24215 = 16'd24215;
  localparam logic [15:0] K_23315 = 16'd23315;
  localparam logic [15:0] K_23115 = 16'd23115;
  localparam logic [15:0] K_22315 = 16'd22315;
  localparam logic [15:0] K_21915 = 16'd21915;
  localparam logic [15:0] K_21315 = 16'd21315;
  localparam logic [15:0] K_20915 = 16'd20915;
  localparam logic [15:0] K_20315 = 16'd20315;
  localparam logic [15:0] K_19715 = 16'd19715;
  localparam logic [15:0] K_19315 = 16'd19315;
  localparam logic [15:0] K_19215 = 16'd19215;
  localparam logic [15:0] K_18315 = 16'd18315;
  localparam logic [15:0] K_17315 = 16'd17315;

  // Scale of the segment value: num = d * k10 + c * SCALE, result = num / SCALE
  localparam logic [9:0]  SCALE     = 10'd1000;
  // Saturation bound: num at or above this gives 255
  localparam logic signed [25:0] SAT_NUM = 26'sd256000;
  // Reciprocal of SCALE, exact for num below 2^18
  localparam logic [16:0] RECIP     = 17'd67109;
  localparam int unsigned RECIP_SH  = 26;

  typedef struct packed {
    logic [15:0] temperature;
    logic        in_last;
  } icm_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_last;
  } icm_out_t;

  // One curve segment: c + (t - a) * k10 / 1000 when up, c + (a - t) * k10 / 1000 otherwise
  typedef struct packed {
    logic [15:0] a;
    logic        up;
    logic [7:0]  k10;
    logic [7:0]  c;
  } icm_seg_t;

  typedef struct packed {
    icm_seg_t r;
    icm_seg_t g;
    icm_seg_t b;
  } icm_rgb_seg_t;

  function automatic icm_seg_t mk(input logic [15:0] a, input logic up,
                                  input logic [7:0] k10, input logic [7:0] c);
    icm_seg_t s;
    s.a   = a;
    s.up  = up;
    s.k10 = k10;
    s.c   = c;
    return s;
  endfunction

  // Flat level: zero slope
  function automatic icm_seg_t flat(input logic [7:0] c);
    return mk(16'd0, 1'b1, 8'd0, c);
  endfunction

  function automatic icm_seg_t bd_grey(input logic [15:0] t);
    if (t > K_30315) return flat(8'd0);
    if (t > K_28215) return mk(K_30315, 1'b0, 8'd120, 8'd0);
    if (t > K_24215) return mk(K_28215, 1'b0, 8'd20, 8'd100);
    if (t > K_23115) return flat(8'd80);
    if (t > K_21915) return flat(8'd130);
    if (t > K_20915) return flat(8'd190);
    if (t > K_20315) return flat(8'd0);
    if (t > K_19715) return flat(8'd255);
    if (t > K_19215) return flat(8'd170);
    return flat(8'd120);
  endfunction

  function automatic icm_seg_t split_r(input logic [15:0] t);
    if (t > K_30315) return flat(8'd0);
    if (t > K_24315) return mk(K_30315, 1'b0, 8'd40, 8'd0);
    if (t > K_22315) return flat(8'd50);
    if (t > K_20315) return flat(8'd0);
    if (t > K_19315) return mk(K_20315, 1'b0, 8'd150, 8'd100);
    if (t > K_18315) return mk(K_18315, 1'b1, 8'd250, 8'd0);
    return mk(K_17315, 1'b1, 8'd250, 8'd0);
  endfunction

  function automatic icm_seg_t split_g(input logic [15:0] t);
    if (t > K_30315) return flat(8'd0);
    if (t > K_24315) return mk(K_30315, 1'b0, 8'd40, 8'd0);
    if (t > K_22315) return mk(K_22315, 1'b1, 8'd60, 8'd120);
    if (t > K_21315) return flat(8'd0);
    if (t > K_20315) return mk(K_21315, 1'b0, 8'd150, 8'd100);
    if (t > K_19315) return flat(8'd0);
    if (t > K_18315) return mk(K_18315, 1'b1, 8'd250, 8'd0);
    return mk(K_17315, 1'b1, 8'd250, 8'd0);
  endfunction

  function automatic icm_seg_t split_b(input logic [15:0] t);
    if (t > K_30315) return flat(8'd0);
    if (t > K_24315) return mk(K_30315, 1'b0, 8'd40, 8'd0);
    if (t > K_22315) return mk(K_22315, 1'b1, 8'd60, 8'd120);
    if (t > K_21315) return mk(K_22315, 1'b0, 8'd150, 8'd100);
    if (t > K_18315) return flat(8'd0);
    return mk(K_17315, 1'b1, 8'd250, 8'd0);
  endfunction

  function automatic icm_seg_t wv_r(input logic [15:0] t);
    if (t > K_27315) return flat(8'd127);
    if (t > K_26315) return mk(K_26315, 1'b1, 8'd108, 8'd20);
    if (t > K_25315) return mk(K_26315, 1'b0, 8'd30, 8'd20);
    if (t > K_24315) return mk(K_25315, 1'b0, 8'd78, 8'd50);
    if (t > K_23315) return mk(K_24315, 1'b0, 8'd128, 8'd127);
    if (t > K_22315) return flat(8'd255);
    if (t > K_20315) return mk(K_20315, 1'b1, 8'd64, 8'd127);
    return flat(8'd128);
  endfunction

  function automatic icm_seg_t wv_g(input logic [15:0] t);
    if (t > K_27315) return flat(8'd0);
    if (t > K_26315) return mk(K_27315, 1'b0, 8'd100, 8'd0);
    if (t > K_25315) return mk(K_26315, 1'b0, 8'd50, 8'd100);
    if (t > K_24315) return mk(K_25315, 1'b0, 8'd105, 8'd150);
    if (t > K_23315) return flat(8'd255);
    if (t > K_22315) return mk(K_22315, 1'b1, 8'd75, 8'd180);
    if (t > K_20315) return mk(K_20315, 1'b1, 8'd90, 8'd0);
    return flat(8'd0);
  endfunction

  function automatic icm_seg_t wv_b(input logic [15:0] t);
    if (t > K_27315) return flat(8'd140);
    if (t > K_26315) return mk(K_27315, 1'b0, 8'd90, 8'd140);
    if (t > K_25315) return mk(K_26315, 1'b0, 8'd25, 8'd230);
    if (t > K_24315) return flat(8'd255);
    if (t > K_23315) return mk(K_23315, 1'b1, 8'd128, 8'd127);
    if (t > K_22315) return mk(K_22315, 1'b1, 8'd28, 8'd100);
    if (t > K_20315) return mk(K_20315, 1'b1, 8'd50, 8'd0);
    return flat(8'd0);
  endfunction

endpackage

// ----- rtl/icm_channel.sv -----
`timescale 1ns / 1ps

// Four-stage segment evaluator for one color channel:
// offset, multiply-add, range check, reciprocal divide.
module icm_channel (
  input  logic              clk,
  input  logic [15:0]       t,
  input  icm_pkg::icm_seg_t seg,
  output logic [7:0]        value
);

  logic signed [16:0] d_r, d_nxt;
  logic [7:0]         k10_r;
  logic [7:0]         c_r;
  logic signed [25:0] num_r, num_nxt;
  logic [17:0]        c_scaled;
  logic               zero_r, zero_nxt;
  logic               sat_r, sat_nxt;
  logic [17:0]        n_r, n_nxt;
  logic [34:0]        prod;
  logic [7:0]         value_r, value_nxt;

  // Form the signed distance from the segment anchor
  always_comb begin
    if (seg.up) begin
      d_nxt = $signed({1'b0, t}) - $signed({1'b0, seg.a});
    end else begin
      d_nxt = $signed({1'b0, seg.a}) - $signed({1'b0, t});
    end
  end

  // Scale the distance and add the segment base
  always_comb begin
    c_scaled = 18'(c_r * icm_pkg::SCALE);
    num_nxt  = 26'(d_r * $signed({1'b0, k10_r})) + $signed({8'd0, c_scaled});
  end

  // Flag negative and saturating values, keep the in-range part
  always_comb begin
    zero_nxt = num_r[25];
    sat_nxt  = !num_r[25] && (num_r >= icm_pkg::SAT_NUM);
    n_nxt    = num_r[17:0];
  end

  // Divide by the scale through the reciprocal and clamp
  always_comb begin
    prod = 35'(n_r * icm_pkg::RECIP);
    if (zero_r) begin
      value_nxt = 8'd0;
    end else if (sat_r) begin
      value_nxt = 8'd255;
    end else begin
      value_nxt = prod[icm_pkg::RECIP_SH +: 8];
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    k10_r   <= seg.k10;
    c_r     <= seg.c;
    num_r   <= num_nxt;
    zero_r  <= zero_nxt;
    sat_r   <= sat_nxt;
    n_r     <= n_nxt;
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ----- rtl/ir_temperature_colormap.sv -----
`timescale 1ns / 1ps

// Channel   Ports                        Direction  Handshake
// input     start, busy, in_data         in         word taken when start && !busy
// result    out_valid, out_data          out        word present for one cycle
// config    cfg_we, cfg_wdata            in         mode written when cfg_we
//
// One pixel word per clock; busy is always low.
// Six register stages: input capture, segment select, offset, multiply-add,
// range check, divide. out_valid is the last stage of the valid chain and
// rises together with the result word from the divide stage.
// Synchronous active-low reset clears the valid chain and sets mode to BD grey.
// Results cannot be held off, so the pipeline never stalls.
module ir_temperature_colormap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  icm_pkg::icm_in_t   in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  output logic               out_valid,
  output icm_pkg::icm_out_t  out_data
);

  logic [1:0]                       mode_r, mode_nxt;
  logic [icm_pkg::PIPE_DEPTH-1:0]   vld_r, vld_nxt;
  logic [icm_pkg::PIPE_DEPTH-1:0]   last_r, last_nxt;
  logic [15:0]                      t0_r;
  logic [15:0]                      t1_r;
  icm_pkg::icm_rgb_seg_t            seg_r, seg_nxt;
  logic [7:0]                       red, green, blue;

  assign busy = 1'b0;

  // Hold mode until a config write
  always_comb begin
    mode_nxt = cfg_we ? cfg_wdata : mode_r;
  end

  // Advance valid and last flags with the data
  always_comb begin
    vld_nxt  = {vld_r[icm_pkg::PIPE_DEPTH-2:0], start};
    last_nxt = {last_r[icm_pkg::PIPE_DEPTH-2:0], in_data.in_last};
  end

  // Pick the segment of each channel for the captured temperature
  always_comb begin
    case (mode_r)
      icm_pkg::MODE_BD: begin
        seg_nxt.r = icm_pkg::bd_grey(t0_r);
        seg_nxt.g = seg_nxt.r;
        seg_nxt.b = seg_nxt.r;
      end
      icm_pkg::MODE_SPLIT: begin
        seg_nxt.r = icm_pkg::split_r(t0_r);
        seg_nxt.g = icm_pkg::split_g(t0_r);
        seg_nxt.b = icm_pkg::split_b(t0_r);
      end
      icm_pkg::MODE_WV: begin
        seg_nxt.r = icm_pkg::wv_r(t0_r);
        seg_nxt.g = icm_pkg::wv_g(t0_r);
        seg_nxt.b = icm_pkg::wv_b(t0_r);
      end
      default: begin
        seg_nxt.r = icm_pkg::flat(8'd0);
        seg_nxt.g = icm_pkg::flat(8'd0);
        seg_nxt.b = icm_pkg::flat(8'd0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= icm_pkg::MODE_BD;
      vld_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    t0_r   <= in_data.temperature;
    t1_r   <= t0_r;
    seg_r  <= seg_nxt;
  end

  icm_channel u_red (
    .clk   (clk),
    .t     (t1_r),
    .seg   (seg_r.r),
    .value (red)
  );

  icm_channel u_green (
    .clk   (clk),
    .t     (t1_r),
    .seg   (seg_r.g),
    .value (green)
  );

  icm_channel u_blue (
    .clk   (clk),
    .t     (t1_r),
    .seg   (seg_r.b),
    .value (blue)
  );

  // Drive the result word from the last stage
  assign out_valid         = vld_r[icm_pkg::PIPE_DEPTH-1];
  assign out_data.red      = red;
  assign out_data.green    = green;
  assign out_data.blue     = blue;
  assign out_data.out_last = last_r[icm_pkg::PIPE_DEPTH-1];

endmodule
